// ----- src/ibt_pkg.sv -----
// ----------------------------------------------------------------------------
// ibt_pkg
// Types, codes and constants shared by the indicator blink timer.
// ----------------------------------------------------------------------------
package ibt_pkg;

	// command codes carried in each input word
	typedef enum logic [1:0] {
		FN_TICK      = 2'd0,
		FN_ON_FOR    = 2'd1,
		FN_BLINK_FOR = 2'd2,
		FN_STOP      = 2'd3
	} func_t;

	// configuration register indexes
	localparam int unsigned CFG_IDX_BITS  = 1;
	localparam int unsigned CFG_DATA_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] CFG_POLARITY_INVERTED = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] CFG_INITIALLY_LIT     = 1'd1;

	// field widths
	localparam int unsigned NOW_BITS    = 48;
	localparam int unsigned DUR_BITS    = 32;
	localparam int unsigned PERIOD_BITS = 32;
	localparam int unsigned DUTY_BITS   = 7;

	localparam int unsigned TIME_BITS_DEF = 48;

	typedef struct packed {
		func_t                  func;
		logic [NOW_BITS-1:0]    now_us;
		logic [DUR_BITS-1:0]    on_duration_us;
		logic [PERIOD_BITS-1:0] blink_period_us;
		logic [DUTY_BITS-1:0]   duty_percent;
	} cmd_word_t;

	typedef struct packed {
		logic lamp_lit;
		logic pin_level;
	} res_word_t;

	// floor(p*d/100) is taken as (p * RECIP_TAB[d]) >> RECIP_SHIFT, with the
	// entries rounded up; the rounding error stays below 1/128 of a unit for a
	// 32-bit period, so the quotient is exact.
	localparam int unsigned DUTY_MAX    = 100;
	localparam int unsigned RECIP_SHIFT = 39;
	localparam int unsigned RECIP_BITS  = 40;
	localparam int unsigned RECIP_HALF  = RECIP_BITS / 2;

	typedef logic [DUTY_MAX:0][RECIP_BITS-1:0] recip_tab_t;

	function automatic recip_tab_t build_recip();
		recip_tab_t t;
		for (int d = 0; d <= DUTY_MAX; d++) begin
			t[d] = RECIP_BITS'(((64'(d) << RECIP_SHIFT) + 64'(DUTY_MAX - 1)) / 64'(DUTY_MAX));
		end
		return t;
	endfunction

	localparam recip_tab_t RECIP_TAB = build_recip();

endpackage

// ----- src/indicator_blink_timer_top.sv -----
// ----------------------------------------------------------------------------
// indicator_blink_timer_top
// Indicator light driver: on, timed on, blinking with duty cycle, and stop.
// ----------------------------------------------------------------------------
// Stages: input register, partial products, lengths and deadline, result.
// Throughput: one word per cycle while the result side does not stall; the state
// stage (deadline and toggle compare plus the next-toggle add) is combinational.
// Reset: clears all stage valids and timer state, light off, polarity normal.
// ----------------------------------------------------------------------------
module indicator_blink_timer_top
	import ibt_pkg::*;
#(
	parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     cmd_valid,
	output logic                     cmd_stall,
	input  cmd_word_t                cmd,
	output logic                     res_valid,
	input  logic                     res_stall,
	output res_word_t                res,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data
);

	localparam int unsigned PP_BITS   = PERIOD_BITS + RECIP_HALF;
	localparam int unsigned PROD_BITS = PERIOD_BITS + RECIP_BITS;

	function automatic logic [TIME_BITS-1:0] time_add(
		input logic [TIME_BITS-1:0] t,
		input logic [DUR_BITS-1:0]  d
	);
		logic [TIME_BITS:0] s;
		s = {1'b0, t} + (TIME_BITS+1)'(d);
		return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
	endfunction

	// ---------------- flow control ----------------
	logic v_s1, v_s2, v_s3, res_valid_q;
	logic rdy_out, rdy_s3, rdy_s2, rdy_s1;

	assign rdy_out   = !res_valid_q || !res_stall;
	assign rdy_s3    = !v_s3 || rdy_out;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign cmd_stall = !rdy_s1;
	assign res_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (rdy_s1)  v_s1        <= cmd_valid;
			if (rdy_s2)  v_s2        <= v_s1;
			if (rdy_s3)  v_s3        <= v_s2;
			if (rdy_out) res_valid_q <= v_s3;
		end
	end

	// ---------------- stage 1: input register ----------------
	cmd_word_t cmd_s1;

	always_ff @(posedge clk) begin
		if (rdy_s1) cmd_s1 <= cmd;
	end

	logic [DUTY_BITS-1:0]   duty_sat;
	logic [RECIP_BITS-1:0]  recip;
	logic [PP_BITS-1:0]     pp_lo, pp_hi;

	assign duty_sat = (cmd_s1.duty_percent > DUTY_BITS'(DUTY_MAX)) ?
		DUTY_BITS'(DUTY_MAX) : cmd_s1.duty_percent;
	assign recip = RECIP_TAB[duty_sat];
	assign pp_lo = PP_BITS'(cmd_s1.blink_period_us) * PP_BITS'(recip[RECIP_HALF-1:0]);
	assign pp_hi = PP_BITS'(cmd_s1.blink_period_us) *
		PP_BITS'(recip[RECIP_BITS-1:RECIP_HALF]);

	// ---------------- stage 2: partial products ----------------
	func_t                  func_s2;
	logic [TIME_BITS-1:0]   now_s2;
	logic [DUR_BITS-1:0]    dur_s2;
	logic [PERIOD_BITS-1:0] period_s2;
	logic [PP_BITS-1:0]     pp_lo_s2, pp_hi_s2;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			func_s2   <= cmd_s1.func;
			now_s2    <= TIME_BITS'(cmd_s1.now_us);
			dur_s2    <= cmd_s1.on_duration_us;
			period_s2 <= cmd_s1.blink_period_us;
			pp_lo_s2  <= pp_lo;
			pp_hi_s2  <= pp_hi;
		end
	end

	logic [PROD_BITS-1:0]   prod;
	logic [PERIOD_BITS-1:0] on_len;

	assign prod   = {pp_hi_s2, {RECIP_HALF{1'b0}}} + PROD_BITS'(pp_lo_s2);
	assign on_len = prod[RECIP_SHIFT +: PERIOD_BITS];

	// ---------------- stage 3: lengths and deadline ----------------
	func_t                  func_s3;
	logic [TIME_BITS-1:0]   now_s3;
	logic [TIME_BITS-1:0]   deadline_s3;
	logic                   dur_nz_s3;
	logic [PERIOD_BITS-1:0] on_len_s3, off_len_s3;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			func_s3     <= func_s2;
			now_s3      <= now_s2;
			deadline_s3 <= time_add(now_s2, dur_s2);
			dur_nz_s3   <= (dur_s2 != '0);
			on_len_s3   <= on_len;
			off_len_s3  <= period_s2 - on_len;
		end
	end

	// ---------------- state stage ----------------
	logic                   polarity_q;
	logic                   lit_q, off_armed_q, blink_en_q;
	logic [TIME_BITS-1:0]   off_deadline_q, next_toggle_q;
	logic [PERIOD_BITS-1:0] on_len_q, off_len_q;

	logic                   lit_d, off_armed_d, blink_en_d;
	logic [TIME_BITS-1:0]   off_deadline_d, next_toggle_d;
	logic [PERIOD_BITS-1:0] on_len_d, off_len_d;
	logic                   step;

	assign step = v_s3 && rdy_out;

	always_comb begin
		lit_d          = lit_q;
		off_armed_d    = off_armed_q;
		blink_en_d     = blink_en_q;
		off_deadline_d = off_deadline_q;
		next_toggle_d  = next_toggle_q;
		on_len_d       = on_len_q;
		off_len_d      = off_len_q;
		case (func_s3)
			FN_ON_FOR, FN_BLINK_FOR: begin
				lit_d       = 1'b1;
				off_armed_d = dur_nz_s3;
				if (dur_nz_s3) off_deadline_d = deadline_s3;
				blink_en_d  = (func_s3 == FN_BLINK_FOR);
				if (func_s3 == FN_BLINK_FOR) begin
					on_len_d      = on_len_s3;
					off_len_d     = off_len_s3;
					next_toggle_d = time_add(now_s3, on_len_s3);
				end
			end
			FN_STOP: begin
				lit_d       = 1'b0;
				off_armed_d = 1'b0;
				blink_en_d  = 1'b0;
			end
			default: begin
				// deadline wins over a toggle due at the same time
				if (off_armed_q && now_s3 >= off_deadline_q) begin
					lit_d       = 1'b0;
					off_armed_d = 1'b0;
					blink_en_d  = 1'b0;
				end else if (blink_en_q && now_s3 >= next_toggle_q) begin
					lit_d         = !lit_q;
					next_toggle_d = time_add(now_s3, lit_q ? off_len_q : on_len_q);
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			polarity_q     <= 1'b0;
			lit_q          <= 1'b0;
			off_armed_q    <= 1'b0;
			blink_en_q     <= 1'b0;
			off_deadline_q <= '0;
			next_toggle_q  <= '0;
			on_len_q       <= '0;
			off_len_q      <= '0;
		end else begin
			if (step) begin
				lit_q          <= lit_d;
				off_armed_q    <= off_armed_d;
				blink_en_q     <= blink_en_d;
				off_deadline_q <= off_deadline_d;
				next_toggle_q  <= next_toggle_d;
				on_len_q       <= on_len_d;
				off_len_q      <= off_len_d;
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_POLARITY_INVERTED: polarity_q <= cfg_data[0];
					CFG_INITIALLY_LIT:     lit_q      <= cfg_data[0];
					default: ;
				endcase
			end
		end
	end

	// ---------------- result register ----------------
	res_word_t res_q;

	always_ff @(posedge clk) begin
		if (step) begin
			res_q.lamp_lit  <= lit_d;
			res_q.pin_level <= lit_d ^ polarity_q;
		end
	end

	assign res = res_q;

	// ---------------- assertions ----------------
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (v_s1 && v_s2 && v_s3 && res_valid_q && res_stall))
		else $error("command side stalled with room in the pipeline");

	a_stop_darkens: assert property (@(posedge clk) disable iff (!arst_n)
		(step && func_s3 == FN_STOP) |=> (!res.lamp_lit && !blink_en_q && !off_armed_q))
		else $error("stop left the light or a timer active");

	a_blink_arms: assert property (@(posedge clk) disable iff (!arst_n)
		(step && func_s3 == FN_BLINK_FOR) |=> (res.lamp_lit && blink_en_q &&
			on_len_q + off_len_q == $past(on_len_s3 + off_len_s3)))
		else $error("blink command did not start blinking");

	a_lit_tracks_state: assert property (@(posedge clk) disable iff (!arst_n)
		step |=> (res.lamp_lit == lit_q))
		else $error("result word disagrees with light state");

endmodule

// ----- tb/sv/tb_indicator_blink_timer_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_indicator_blink_timer_top
// Self-checking bench for the indicator blink timer.
// A short table of directed commands covers reset state, timed off, blinking
// with saturated, zero and full duty, zero period and time saturation. Random
// phases then stream ticks over a rising clock with on_for, blink_for, stop
// and noise words mixed in, under every register setting. Each result word is
// compared with the table or a cycle-free light model; both sides idle at random.
// ----------------------------------------------------------------------------
module tb_indicator_blink_timer_top
	import ibt_pkg::*;
();

	localparam int          TW          = NOW_BITS;
	localparam logic [TW-1:0] MAXT      = '1;
	localparam int          PIPE_LAT    = 3;
	localparam int          PCT_FULL    = 100;
	localparam int          FROM_MODEL  = -1;
	localparam int          PHASES      = 6;
	localparam int          PHASE_ITEMS = 222;
	localparam int          CYCLE_LIMIT = 600000;

	logic                     clk;
	logic                     arst_n    = 1'b0;
	logic                     cmd_valid = 1'b0;
	logic                     cmd_stall;
	cmd_word_t                cmd       = '0;
	logic                     res_valid;
	logic                     res_stall = 1'b0;
	res_word_t                res;
	logic                     cfg_we    = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = '0;
	logic [CFG_DATA_BITS-1:0] cfg_data  = '0;

	indicator_blink_timer_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// light model state
	logic          m_polarity    = 1'b0;
	logic          m_lit         = 1'b0;
	logic          m_off_armed   = 1'b0;
	logic [TW-1:0] m_off_deadline = '0;
	logic          m_blink_en    = 1'b0;
	logic [31:0]   m_on_len      = '0;
	logic [31:0]   m_off_len     = '0;
	logic [TW-1:0] m_next_toggle = '0;

	res_word_t expected_lamp_q[$];
	int        err_cnt     = 0;
	int        checked_cnt = 0;
	int        sent_cnt    = 0;
	int        func_cnt[4] = '{0, 0, 0, 0};
	int        cycle_cnt   = 0;
	bit        tx_idle     = 1'b1;
	bit        rx_idle     = 1'b1;

	typedef struct {
		cmd_word_t w;
		int        want;
	} probe_t;

	probe_t probe_rows[$];

	function automatic logic [TW-1:0] sat_time_add(input logic [TW-1:0] t,
			input logic [31:0] d);
		logic [TW:0] s;
		s = (TW+1)'(t) + (TW+1)'(d);
		return s[TW] ? MAXT : s[TW-1:0];
	endfunction

	task automatic go_dark();
		m_blink_en  = 1'b0;
		m_off_armed = 1'b0;
		m_lit       = 1'b0;
	endtask

	task automatic light_on(input logic [TW-1:0] now, input logic [31:0] dur);
		m_blink_en = 1'b0;
		m_lit      = 1'b1;
		m_off_armed = (dur != '0);
		if (dur != '0)
			m_off_deadline = sat_time_add(now, dur);
	endtask

	task automatic predict_lamp(input cmd_word_t w, output res_word_t r);
		logic [6:0]  duty;
		logic [63:0] prod;
		case (w.func)
			FN_ON_FOR: light_on(w.now_us, w.on_duration_us);
			FN_BLINK_FOR: begin
				duty = (w.duty_percent > 7'(PCT_FULL)) ? 7'(PCT_FULL) : w.duty_percent;
				light_on(w.now_us, w.on_duration_us);
				prod          = 64'(w.blink_period_us) * 64'(duty);
				m_on_len      = 32'(prod / 64'(PCT_FULL));
				m_off_len     = w.blink_period_us - m_on_len;
				m_blink_en    = 1'b1;
				m_next_toggle = sat_time_add(w.now_us, m_on_len);
			end
			FN_STOP: go_dark();
			default: begin
				// deadline wins over a toggle due at the same time
				if (m_off_armed && w.now_us >= m_off_deadline) begin
					go_dark();
				end else if (m_blink_en && w.now_us >= m_next_toggle) begin
					m_lit         = ~m_lit;
					m_next_toggle = sat_time_add(w.now_us, m_lit ? m_on_len : m_off_len);
				end
			end
		endcase
		r.lamp_lit  = m_lit;
		r.pin_level = m_lit ^ m_polarity;
	endtask

	function automatic void add_probe(input func_t f, input logic [TW-1:0] now,
			input logic [31:0] dur, input logic [31:0] per, input logic [6:0] duty,
			input int want);
		probe_t p;
		p.w.func            = f;
		p.w.now_us          = now;
		p.w.on_duration_us  = dur;
		p.w.blink_period_us = per;
		p.w.duty_percent    = duty;
		p.want              = want;
		probe_rows.push_back(p);
	endfunction

	// drive one command word and log its expected result on acceptance
	task automatic send_word(input cmd_word_t w, input int want);
		int        gap;
		res_word_t r;
		gap = tx_idle ? $urandom_range(0, 19) : 0;
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		cmd       <= w;
		cmd_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (cmd_stall);
		predict_lamp(w, r);
		if (want != FROM_MODEL) begin
			r.lamp_lit  = want[0];
			r.pin_level = want[0] ^ m_polarity;
		end
		expected_lamp_q.push_back(r);
		func_cnt[w.func]++;
		sent_cnt++;
		if (sent_cnt % 48 == 0)
			tx_idle = ($urandom_range(0, 2) != 0);
	endtask

	task automatic write_cfg(input logic [CFG_IDX_BITS-1:0] idx, input logic val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= CFG_DATA_BITS'(val);
		@(posedge clk);
		if (idx == CFG_POLARITY_INVERTED) begin
			m_polarity = val;
		end else if (idx == CFG_INITIALLY_LIT) begin
			m_lit      = val;
		end
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		while (expected_lamp_q.size() != 0)
			@(posedge clk);
		repeat (PIPE_LAT + 2) @(posedge clk);
	endtask

	// result side stall
	initial begin
		int n;
		int got;
		got = 0;
		@(posedge arst_n);
		forever begin
			n = rx_idle ? $urandom_range(0, 19) : 0;
			if (n > 0) begin
				res_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			res_stall <= 1'b0;
			do begin
				@(posedge clk);
			end while (!res_valid);
			got++;
			if (got % 40 == 0)
				rx_idle = ($urandom_range(0, 2) != 0);
		end
	end

	always @(posedge clk) begin : res_check
		res_word_t want;
		if (arst_n && res_valid && !res_stall) begin
			if (expected_lamp_q.size() == 0) begin
				$error("result word with nothing expected: lamp_lit %0b pin_level %0b",
					res.lamp_lit, res.pin_level);
				err_cnt++;
			end else begin
				want = expected_lamp_q.pop_front();
				checked_cnt++;
				if (res.lamp_lit !== want.lamp_lit) begin
					$error("lamp_lit: expected %0b, got %0b", want.lamp_lit, res.lamp_lit);
					err_cnt++;
				end
				if (res.pin_level !== want.pin_level) begin
					$error("pin_level: expected %0b, got %0b", want.pin_level, res.pin_level);
					err_cnt++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d words outstanding", cycle_cnt,
				expected_lamp_q.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	initial begin
		cmd_word_t     w;
		logic [TW-1:0] t;
		logic [TW-1:0] step;
		logic          pol;
		logic          lit;
		int            r;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset defaults: light off, normal polarity
		add_probe(FN_TICK,      '0,        '0,    '0,   '0,  0);
		add_probe(FN_ON_FOR,    48'd100,   '0,    '0,   '0,  1);
		add_probe(FN_TICK,      MAXT,      '0,    '0,   '0,  1);
		add_probe(FN_STOP,      '0,        '1,    '1,   '1,  0);
		add_probe(FN_ON_FOR,    48'd1000,  32'd500, '0, '0,  1);
		add_probe(FN_TICK,      48'd1499,  '0,    '0,   '0,  FROM_MODEL);
		add_probe(FN_TICK,      48'd1500,  '0,    '0,   '0,  0);
		add_probe(FN_BLINK_FOR, 48'd2000,  '0, 32'd1000, 7'd30, 1);
		add_probe(FN_TICK,      48'd2299,  '0,    '0,   '0,  FROM_MODEL);
		add_probe(FN_TICK,      48'd2300,  '0,    '0,   '0,  FROM_MODEL);
		add_probe(FN_TICK,      48'd3000,  '0,    '0,   '0,  FROM_MODEL);
		// duty above full: off-time collapses to zero
		add_probe(FN_BLINK_FOR, 48'd4000,  '0, 32'd1000, 7'd127, 1);
		add_probe(FN_TICK,      48'd5000,  '0,    '0,   '0,  FROM_MODEL);
		add_probe(FN_TICK,      48'd5000,  '0,    '0,   '0,  FROM_MODEL);
		// zero period: toggle on every tick
		add_probe(FN_BLINK_FOR, 48'd7000,  '0,    '0, 7'd50, 1);
		add_probe(FN_TICK,      48'd7000,  '0,    '0,   '0,  FROM_MODEL);
		add_probe(FN_TICK,      48'd7001,  '0,    '0,   '0,  FROM_MODEL);
		add_probe(FN_BLINK_FOR, 48'd8000,  '0, 32'd1000, 7'd0, 1);
		add_probe(FN_TICK,      48'd8000,  '0,    '0,   '0,  FROM_MODEL);
		add_probe(FN_BLINK_FOR, 48'd9000,  32'd2500, 32'd1000, 7'd50, 1);
		add_probe(FN_TICK,      48'd11500, '0,    '0,   '0,  0);
		// sums past the top of time saturate
		add_probe(FN_ON_FOR,    MAXT - 10, '1,    '0,   '0,  1);
		add_probe(FN_TICK,      MAXT,      '0,    '0,   '0,  0);
		add_probe(FN_BLINK_FOR, MAXT - 5,  '0,    '1, 7'd100, 1);
		add_probe(FN_TICK,      MAXT,      '0,    '0,   '0,  FROM_MODEL);

		foreach (probe_rows[i])
			send_word(probe_rows[i].w, probe_rows[i].want);

		for (int ph = 0; ph < PHASES; ph++) begin
			drain();
			if (ph < 4) begin
				pol = (ph == 1 || ph == 2);
				lit = (ph == 1 || ph == 3);
			end else begin
				pol = 1'($urandom_range(0, 1));
				lit = 1'($urandom_range(0, 1));
			end
			if ($urandom_range(0, 1)) begin
				write_cfg(CFG_POLARITY_INVERTED, pol);
				write_cfg(CFG_INITIALLY_LIT, lit);
			end else begin
				write_cfg(CFG_INITIALLY_LIT, lit);
				write_cfg(CFG_POLARITY_INVERTED, pol);
			end
			cfg_we <= 1'b0;

			if (ph == 2)
				t = MAXT - TW'($urandom_range(0, 60000));
			else if (ph == 5)
				t = TW'({$urandom(), $urandom()}) >> 2;
			else
				t = TW'($urandom_range(0, 1000));

			repeat (PHASE_ITEMS) begin
				// unused fields carry garbage on purpose
				w.now_us          = t;
				w.on_duration_us  = $urandom();
				w.blink_period_us = $urandom();
				w.duty_percent    = 7'($urandom_range(0, 127));
				r = $urandom_range(0, 99);
				if (r < 60) begin
					w.func = FN_TICK;
					step = ($urandom_range(0, 19) == 0) ? TW'($urandom_range(0, 20000))
						: TW'($urandom_range(0, 400));
					t = (MAXT - t < step) ? MAXT : t + step;
					w.now_us = t;
				end else if (r < 90) begin
					w.func = (r < 70) ? FN_ON_FOR : (r < 85) ? FN_BLINK_FOR : FN_STOP;
					case ($urandom_range(0, 11))
						0, 1:    w.on_duration_us = '0;
						2:       w.on_duration_us = $urandom();
						default: w.on_duration_us = $urandom_range(1, 3000);
					endcase
					case ($urandom_range(0, 11))
						0:       w.blink_period_us = '0;
						1:       w.blink_period_us = $urandom();
						default: w.blink_period_us = $urandom_range(1, 1500);
					endcase
				end else begin
					// noise: any command at any time
					w.func   = func_t'($urandom_range(0, 3));
					w.now_us = TW'({$urandom(), $urandom()});
				end
				send_word(w, FROM_MODEL);
			end
		end

		cmd_valid <= 1'b0;
		while (expected_lamp_q.size() != 0)
			@(posedge clk);
		repeat (4 * PIPE_LAT + 8) @(posedge clk);

		$display("Checked %0d result words for %0d commands:", checked_cnt, sent_cnt);
		$display("  %0d tick, %0d on_for, %0d blink_for, %0d stop",
			func_cnt[FN_TICK], func_cnt[FN_ON_FOR],
			func_cnt[FN_BLINK_FOR], func_cnt[FN_STOP]);
		$display("Ran %0d register settings with random gaps and stalls, %0d mismatches",
			PHASES + 1, err_cnt);
		if (err_cnt == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
